>>> rtl/assert_macros.svh
// Assertion macros shared by the mixed-radix converter RTL.
// No dependencies; included inside module bodies that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clock, rstn, prop) \
	label: assert property (@(posedge clock) disable iff (!rstn) prop) \
		else $error("assertion failed");

// Concurrent assertion on the house clock and reset names.
`define ASSERT_STD(label, prop) `ASSERT_CLK(label, clk, arst_n, prop)

`endif

>>> rtl/mre_pkg.sv
// Package for the mixed-radix converter: sizes, register indexes, stage struct.
// No dependencies; imported by every module of the block.
package mre_pkg;

	localparam int LANES           = 6;
	localparam int CODE_W          = 60;
	localparam int DIGIT_W         = 10;
	localparam int RADIX_W         = 11;
	localparam int WEIGHT_W        = CODE_W + 1;
	localparam int STEPS_PER_CELL  = 4;
	localparam int DIV_CELLS       = CODE_W / STEPS_PER_CELL;
	localparam int MAX_DIGITS_DEF  = 6;
	localparam int DIGIT_WIDTH_DEF = 10;

	localparam logic [CODE_W-1:0]   CODE_MASK  = {CODE_W{1'b1}};
	localparam logic [WEIGHT_W-1:0] CODE_LIMIT = {1'b1, {CODE_W{1'b0}}};

	typedef enum logic [2:0] {
		CFG_DIGIT_COUNT = 3'd0,
		CFG_RADIX_0     = 3'd1,
		CFG_RADIX_1     = 3'd2,
		CFG_RADIX_2     = 3'd3,
		CFG_RADIX_3     = 3'd4,
		CFG_RADIX_4     = 3'd5,
		CFG_RADIX_5     = 3'd6
	} cfg_idx_t;

	typedef enum logic {
		OP_ENCODE = 1'b0,
		OP_DECODE = 1'b1
	} op_t;

	// Everything one item carries from cell to cell.
	typedef struct packed {
		op_t                              opcode;
		logic [LANES-1:0][DIGIT_W-1:0]    digit;
		logic [CODE_W-1:0]                code;
		logic [WEIGHT_W-1:0]              weight;
		logic                             over;
		logic                             flag;
		logic [CODE_W-1:0]                work;
		logic [DIGIT_W-1:0]               rem;
		logic [LANES-1:0][DIGIT_W-1:0]    dec;
	} stage_t;

endpackage

>>> rtl/mixed_radix_encode_decode.sv
// Top level of the mixed-radix encoder and decoder: config registers and cell chain.
// Depends on mre_pkg, mre_enc_cell, mre_div_cell and assert_macros.svh.
//
// Usage. An item is taken at a rising edge with start high and busy low. busy is
// high only during reset and until the first clock edge after it, so an item may be offered
// in every cycle. opcode 0 encodes digit_0..digit_5 into code_out; opcode 1
// decodes code_in into digit_out_0..digit_out_5. Each result beat appears on the
// result ports for one cycle with done high and must be taken then; the receiver
// cannot stall, and none is needed since the chain never stops.
// Each item passes through the input register, the cell chain and the result
// register; throughput is one item per cycle. Each digit lane is one encode cell,
// which holds the multipliers for digit times weight and weight times radix,
// followed by fifteen division cells that each resolve four quotient bits of
// the code by that lane's radix.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready and must only be written while no item is in flight. Reset sets the digit
// count to 1 and all radices to 1024 and empties the chain.
module mixed_radix_encode_decode #(
	parameter int MAX_DIGITS  = mre_pkg::MAX_DIGITS_DEF,
	parameter int DIGIT_WIDTH = mre_pkg::DIGIT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          opcode,
	input  logic [mre_pkg::CODE_W-1:0]    code_in,
	input  logic [DIGIT_WIDTH-1:0]        digit_0,
	input  logic [DIGIT_WIDTH-1:0]        digit_1,
	input  logic [DIGIT_WIDTH-1:0]        digit_2,
	input  logic [DIGIT_WIDTH-1:0]        digit_3,
	input  logic [DIGIT_WIDTH-1:0]        digit_4,
	input  logic [DIGIT_WIDTH-1:0]        digit_5,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [mre_pkg::RADIX_W-1:0]   cfg_data,
	output logic                          done,
	output logic [mre_pkg::CODE_W-1:0]    code_out,
	output logic [DIGIT_WIDTH-1:0]        digit_out_0,
	output logic [DIGIT_WIDTH-1:0]        digit_out_1,
	output logic [DIGIT_WIDTH-1:0]        digit_out_2,
	output logic [DIGIT_WIDTH-1:0]        digit_out_3,
	output logic [DIGIT_WIDTH-1:0]        digit_out_4,
	output logic [DIGIT_WIDTH-1:0]        digit_out_5,
	output logic                          out_of_range
);
	import mre_pkg::*;
	`include "assert_macros.svh"

	localparam int NUM_CELLS      = (MAX_DIGITS < LANES) ? MAX_DIGITS : LANES;
	localparam int CELLS_PER_LANE = 1 + DIV_CELLS;
	localparam int NSTAGE         = NUM_CELLS * CELLS_PER_LANE;
	localparam int LATENCY        = NSTAGE + 2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(1) << DIGIT_WIDTH;
	localparam logic [RADIX_W-1:0] RADIX_ONE = RADIX_W'(1);

	// Configuration registers.
	logic [2:0]                    count_q;
	logic [LANES-1:0][RADIX_W-1:0] radix_q;
	logic                          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 3'd1;
			radix_q <= {LANES{RADIX_W'(1024)}};
			busy_q  <= 1'b1;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_DIGIT_COUNT: count_q    <= cfg_data[2:0];
					CFG_RADIX_0:     radix_q[0] <= cfg_data;
					CFG_RADIX_1:     radix_q[1] <= cfg_data;
					CFG_RADIX_2:     radix_q[2] <= cfg_data;
					CFG_RADIX_3:     radix_q[3] <= cfg_data;
					CFG_RADIX_4:     radix_q[4] <= cfg_data;
					CFG_RADIX_5:     radix_q[5] <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = busy_q;

	// Lanes above the digit count run with radix one: the division then passes
	// the code through untouched with a zero remainder, and encode adds nothing.
	logic [2:0]                    n_eff;
	logic [LANES-1:0]              lane_en;
	logic [LANES-1:0][RADIX_W-1:0] radix_eff;

	always_comb begin
		n_eff = (count_q > 3'(NUM_CELLS)) ? 3'(NUM_CELLS) : count_q;
		for (int i = 0; i < LANES; i++) begin
			lane_en[i] = (3'(i) < n_eff);
			if (!lane_en[i] || radix_q[i] == '0) begin
				radix_eff[i] = RADIX_ONE;
			end else if (radix_q[i] > RADIX_MAX) begin
				radix_eff[i] = RADIX_MAX;
			end else begin
				radix_eff[i] = radix_q[i];
			end
		end
	end

	// Input stage.
	stage_t st    [NSTAGE+1];
	logic   vld   [NSTAGE+1];
	logic   accept;
	stage_t st_in;

	assign accept = start && !busy_q;

	always_comb begin
		st_in          = '0;
		st_in.opcode   = op_t'(opcode);
		st_in.digit[0] = DIGIT_W'(digit_0);
		st_in.digit[1] = DIGIT_W'(digit_1);
		st_in.digit[2] = DIGIT_W'(digit_2);
		st_in.digit[3] = DIGIT_W'(digit_3);
		st_in.digit[4] = DIGIT_W'(digit_4);
		st_in.digit[5] = DIGIT_W'(digit_5);
		st_in.weight   = WEIGHT_W'(1);
		st_in.work     = code_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld[0] <= 1'b0;
		end else begin
			vld[0] <= accept;
		end
	end

	always_ff @(posedge clk) begin
		st[0] <= st_in;
	end

	// The cell chain: per lane one encode cell, then the division cells.
	for (genvar l = 0; l < NUM_CELLS; l++) begin : g_lane
		mre_enc_cell #(
			.LANE (l)
		) u_enc (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (lane_en[l]),
			.radix     (radix_eff[l]),
			.valid_in  (vld[l*CELLS_PER_LANE]),
			.st_in     (st[l*CELLS_PER_LANE]),
			.valid_out (vld[l*CELLS_PER_LANE+1]),
			.st_out    (st[l*CELLS_PER_LANE+1])
		);
		for (genvar c = 0; c < DIV_CELLS; c++) begin : g_div
			mre_div_cell #(
				.LANE (l),
				.CELL (c)
			) u_div (
				.clk       (clk),
				.arst_n    (arst_n),
				.radix     (radix_eff[l]),
				.valid_in  (vld[l*CELLS_PER_LANE+1+c]),
				.st_in     (st[l*CELLS_PER_LANE+1+c]),
				.valid_out (vld[l*CELLS_PER_LANE+2+c]),
				.st_out    (st[l*CELLS_PER_LANE+2+c])
			);
		end
	end

	// Result register: pick the encode or decode view and finish the flags.
	stage_t                        fin;
	logic                          done_q;
	logic [CODE_W-1:0]             code_q;
	logic [LANES-1:0][DIGIT_W-1:0] dig_q;
	logic                          oor_q;

	assign fin = st[NSTAGE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld[NSTAGE];
		end
	end

	always_ff @(posedge clk) begin
		if (fin.opcode == OP_ENCODE) begin
			code_q <= fin.over ? CODE_MASK : fin.code;
			dig_q  <= '0;
			oor_q  <= fin.flag || fin.over;
		end else begin
			code_q <= '0;
			dig_q  <= fin.dec;
			oor_q  <= (fin.work != '0);
		end
	end

	assign done         = done_q;
	assign code_out     = code_q;
	assign digit_out_0  = dig_q[0][DIGIT_WIDTH-1:0];
	assign digit_out_1  = dig_q[1][DIGIT_WIDTH-1:0];
	assign digit_out_2  = dig_q[2][DIGIT_WIDTH-1:0];
	assign digit_out_3  = dig_q[3][DIGIT_WIDTH-1:0];
	assign digit_out_4  = dig_q[4][DIGIT_WIDTH-1:0];
	assign digit_out_5  = dig_q[5][DIGIT_WIDTH-1:0];
	assign out_of_range = oor_q;

	// Every accepted item comes out as a result beat with done high.
	`ASSERT_STD(a_fixed_latency, accept |-> ##(LATENCY) done_q)
	// A result beat is either an encode (no digits) or a decode (no code).
	`ASSERT_STD(a_one_view, done_q |-> (code_q == '0) || (dig_q == '0))
	// Nothing is delivered that did not pass through the chain.
	`ASSERT_STD(a_no_phantom, done_q |-> $past(vld[NSTAGE]))

endmodule

>>> rtl/mre_enc_cell.sv
// Encode cell: adds one digit times its weight and advances the weight.
// Depends on mre_pkg and assert_macros.svh.
module mre_enc_cell #(
	parameter int LANE = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [mre_pkg::RADIX_W-1:0]  radix,
	input  logic                         valid_in,
	input  mre_pkg::stage_t              st_in,
	output logic                         valid_out,
	output mre_pkg::stage_t              st_out
);
	import mre_pkg::*;
	`include "assert_macros.svh"

	logic [DIGIT_W-1:0]            d;
	logic [DIGIT_W+WEIGHT_W-1:0]   prod;
	logic [DIGIT_W+WEIGHT_W-1:0]   sum;
	logic [RADIX_W+WEIGHT_W-1:0]   wprod;
	logic                          fits;
	stage_t                        nxt;
	logic                          valid_q;
	stage_t                        st_q;

	always_comb begin
		nxt  = st_in;
		d    = en ? st_in.digit[LANE] : '0;
		prod = (DIGIT_W+WEIGHT_W)'(d) * (DIGIT_W+WEIGHT_W)'(st_in.weight);
		sum  = (DIGIT_W+WEIGHT_W)'(st_in.code) + prod;
		fits = (sum <= (DIGIT_W+WEIGHT_W)'(CODE_MASK));
		// Once the sum has overflowed it stays saturated; the code is replaced at the end.
		if (d != '0 && !st_in.over) begin
			if (fits) begin
				nxt.code = sum[CODE_W-1:0];
			end else begin
				nxt.over = 1'b1;
			end
		end
		if (RADIX_W'(d) >= radix) begin
			nxt.flag = 1'b1;
		end
		wprod = (RADIX_W+WEIGHT_W)'(st_in.weight) * (RADIX_W+WEIGHT_W)'(radix);
		if (wprod > (RADIX_W+WEIGHT_W)'(CODE_LIMIT)) begin
			nxt.weight = CODE_LIMIT;
		end else begin
			nxt.weight = wprod[WEIGHT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		st_q <= nxt;
	end

	assign valid_out = valid_q;
	assign st_out    = st_q;

	// Every radix is at least one, so the weight can never collapse to zero.
	`ASSERT_STD(a_weight_nonzero, valid_q |-> (st_q.weight != '0))

endmodule

>>> rtl/mre_div_cell.sv
// Division cell: STEPS_PER_CELL restoring long-division steps of the code by one radix.
// Depends on mre_pkg and assert_macros.svh.
module mre_div_cell #(
	parameter int LANE = 0,
	parameter int CELL = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [mre_pkg::RADIX_W-1:0]  radix,
	input  logic                         valid_in,
	input  mre_pkg::stage_t              st_in,
	output logic                         valid_out,
	output mre_pkg::stage_t              st_out
);
	import mre_pkg::*;
	`include "assert_macros.svh"

	localparam int TOP = CODE_W - 1 - CELL * STEPS_PER_CELL;

	logic [DIGIT_W-1:0]  rem;
	logic [RADIX_W-1:0]  trial;
	logic [CODE_W-1:0]   w;
	stage_t              nxt;
	logic                valid_q;
	stage_t              st_q;

	// Code bits are consumed from the top; each is replaced by its quotient bit.
	always_comb begin
		nxt = st_in;
		w   = st_in.work;
		rem = (CELL == 0) ? '0 : st_in.rem;
		for (int s = 0; s < STEPS_PER_CELL; s++) begin
			trial = {rem, w[TOP-s]};
			if (trial >= radix) begin
				trial    = trial - radix;
				w[TOP-s] = 1'b1;
			end else begin
				w[TOP-s] = 1'b0;
			end
			rem = trial[DIGIT_W-1:0];
		end
		nxt.work = w;
		nxt.rem  = rem;
		if (CELL == DIV_CELLS - 1) begin
			nxt.dec[LANE] = rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		st_q <= nxt;
	end

	assign valid_out = valid_q;
	assign st_out    = st_q;

	`ASSERT_STD(a_rem_below_radix, valid_q |-> (RADIX_W'(st_q.rem) < radix))

endmodule

>>> dv/mixed_radix_encode_decode_tb.sv
// Self-checking testbench for the mixed-radix encoder and decoder.
// Depends on mre_pkg and the mixed_radix_encode_decode RTL; needs no other file.
`timescale 1ns / 100ps

module mixed_radix_encode_decode_tb;
	import mre_pkg::*;

	// Index 7 addresses no register; a write there must leave everything unchanged.
	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 2 + 16 * LANES + 10;
	localparam longint unsigned CODE_MAX = 64'h0FFF_FFFF_FFFF_FFFF;
	localparam longint unsigned CODE_TOP = 64'h1000_0000_0000_0000;

	typedef struct {
		logic [CODE_W-1:0]  code;
		logic [DIGIT_W-1:0] dig[LANES];
		logic               flag;
	} conv_result_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic               opcode;
	logic [CODE_W-1:0]  code_in;
	logic [DIGIT_W-1:0] dig_in[LANES];
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [RADIX_W-1:0] cfg_data;
	logic               done;
	logic [CODE_W-1:0]  code_out;
	logic [DIGIT_W-1:0] dig_out[LANES];
	logic               out_of_range;

	// Shadow copy of the configuration registers, updated on each accepted write beat.
	logic [2:0]         shadow_count;
	logic [RADIX_W-1:0] shadow_radix[LANES];

	conv_result_t pending_results[$];
	int           err_count;
	int           idle_count;

	mixed_radix_encode_decode u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.code_in      (code_in),
		.digit_0      (dig_in[0]),
		.digit_1      (dig_in[1]),
		.digit_2      (dig_in[2]),
		.digit_3      (dig_in[3]),
		.digit_4      (dig_in[4]),
		.digit_5      (dig_in[5]),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.done         (done),
		.code_out     (code_out),
		.digit_out_0  (dig_out[0]),
		.digit_out_1  (dig_out[1]),
		.digit_out_2  (dig_out[2]),
		.digit_out_3  (dig_out[3]),
		.digit_out_4  (dig_out[4]),
		.digit_out_5  (dig_out[5]),
		.out_of_range (out_of_range)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A digit count above the six lanes saturates to six.
	function automatic int lanes_used();
		return (shadow_count > LANES) ? LANES : int'(shadow_count);
	endfunction

	// Radix zero behaves as one, and anything above 1024 is clipped to 1024.
	function automatic longint unsigned radix_of(int lane);
		if (shadow_radix[lane] == 0)
			return 64'd1;
		if (shadow_radix[lane] > 1024)
			return 64'd1024;
		return 64'(shadow_radix[lane]);
	endfunction

	// Product of the radices in use, clipped at 2^60: the count of codes that decode cleanly.
	function automatic longint unsigned code_span();
		longint unsigned span;
		span = 1;
		for (int i = 0; i < lanes_used(); i++)
			span = (span > CODE_TOP / radix_of(i)) ? CODE_TOP : span * radix_of(i);
		return span;
	endfunction

	// Works out the converter's answer for one item under the current shadow configuration.
	function automatic conv_result_t convert(input op_t op, input logic [CODE_W-1:0] code_val,
			input logic [DIGIT_W-1:0] digs[LANES]);
		conv_result_t    res;
		longint unsigned acc, weight, d, r;
		bit              over;
		res.code = '0;
		res.flag = 1'b0;
		for (int i = 0; i < LANES; i++)
			res.dig[i] = '0;
		if (op == OP_ENCODE) begin
			acc = 0;
			weight = 1;
			over = 0;
			for (int i = 0; i < lanes_used(); i++) begin
				d = 64'(digs[i]);
				r = radix_of(i);
				if (d >= r)
					res.flag = 1'b1;
				if (d != 0 && !over) begin
					if (weight > (CODE_MAX - acc) / d)
						over = 1;
					else
						acc += d * weight;
				end
				weight = (weight > CODE_TOP / r) ? CODE_TOP : weight * r;
			end
			// An exact sum that does not fit saturates to all ones.
			if (over) begin
				res.flag = 1'b1;
				acc = CODE_MAX;
			end
			res.code = acc[CODE_W-1:0];
		end else begin
			acc = 64'(code_val);
			for (int i = 0; i < lanes_used(); i++) begin
				r = radix_of(i);
				res.dig[i] = DIGIT_W'(acc % r);
				acc = acc / r;
			end
			// Anything left above the top digit in use means the code was out of range.
			res.flag = (acc != 0);
		end
		return res;
	endfunction

	// Every result beat is compared against the oldest outstanding prediction.
	always @(posedge clk) begin
		conv_result_t exp_res;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no prediction waiting");
				err_count++;
			end else begin
				exp_res = pending_results.pop_front();
				if (code_out !== exp_res.code) begin
					$error("code_out expected %0h actual %0h", exp_res.code, code_out);
					err_count++;
				end
				for (int i = 0; i < LANES; i++)
					if (dig_out[i] !== exp_res.dig[i]) begin
						$error("digit_out_%0d expected %0d actual %0d", i, exp_res.dig[i],
							dig_out[i]);
						err_count++;
					end
				if (out_of_range !== exp_res.flag) begin
					$error("out_of_range expected %0b actual %0b", exp_res.flag, out_of_range);
					err_count++;
				end
			end
		end
	end

	// Watchdog: ends the run if nothing at all moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Offers one item and returns just after the edge that takes it. start is left high,
	// so a following call in the same step keeps the beat train going without a gap.
	task automatic send_item(input op_t op, input logic [CODE_W-1:0] code_val,
			input logic [DIGIT_W-1:0] digs[LANES]);
		bit taken;
		start <= 1'b1;
		opcode <= op;
		code_in <= code_val;
		for (int i = 0; i < LANES; i++)
			dig_in[i] <= digs[i];
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(convert(op, code_val, digs));
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Stops sending and waits for every predicted result, then lets the chain settle.
	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [RADIX_W-1:0] value);
		bit taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		if (idx == CFG_DIGIT_COUNT)
			shadow_count = value[2:0];
		else if (idx != CFG_UNUSED)
			shadow_radix[idx - 1] = value;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [2:0] count, input logic [RADIX_W-1:0] r[LANES]);
		write_reg(CFG_DIGIT_COUNT, RADIX_W'(count));
		write_reg(CFG_RADIX_0, r[0]);
		write_reg(CFG_RADIX_1, r[1]);
		write_reg(CFG_RADIX_2, r[2]);
		write_reg(CFG_RADIX_3, r[3]);
		write_reg(CFG_RADIX_4, r[4]);
		write_reg(CFG_RADIX_5, r[5]);
	endtask

	function automatic logic [CODE_W-1:0] any_code();
		return CODE_W'({$urandom, $urandom});
	endfunction

	// Mostly codes that decode cleanly; the rest land anywhere in 60 bits.
	function automatic logic [CODE_W-1:0] pick_code();
		longint unsigned span;
		longint unsigned raw;
		span = code_span();
		raw = 64'(any_code());
		if ($urandom_range(0, 3) != 0 && span < CODE_TOP)
			return CODE_W'(raw % span);
		return CODE_W'(raw);
	endfunction

	// Mostly digits below their radix, with some noise across the whole field.
	task automatic pick_digits(output logic [DIGIT_W-1:0] digs[LANES]);
		for (int i = 0; i < LANES; i++)
			if ($urandom_range(0, 4) != 0)
				digs[i] = DIGIT_W'($urandom_range(0, int'(radix_of(i)) - 1));
			else
				digs[i] = DIGIT_W'($urandom);
	endtask

	// Reset configuration: one digit of radix 1024.
	task automatic test_reset_config();
		logic [DIGIT_W-1:0] digs[LANES];
		digs = '{1023, 1023, 5, 7, 9, 11};
		send_item(OP_ENCODE, '0, digs);
		send_item(OP_DECODE, 60'd1023, digs);
		send_item(OP_DECODE, 60'd1024, digs);
		drain();
	endtask

	// Field extremes, both operations and each corner of the configuration.
	task automatic test_directed();
		logic [DIGIT_W-1:0] digs[LANES];
		logic [RADIX_W-1:0] r[LANES];
		r = '{1024, 1024, 1024, 1024, 1024, 1024};
		load_config(3'd6, r);
		digs = '{1023, 1023, 1023, 1023, 1023, 1023};
		send_item(OP_ENCODE, '0, digs);
		send_item(OP_DECODE, '1, digs);
		digs = '{0, 0, 0, 0, 0, 0};
		send_item(OP_ENCODE, '1, digs);
		send_item(OP_DECODE, '0, digs);
		drain();

		// Radix zero acts as one, oversized radices clip; a count of seven clips to six.
		r = '{0, 2047, 1025, 1, 3, 1024};
		load_config(3'd7, r);
		digs = '{1, 1023, 1023, 0, 2, 1023};
		send_item(OP_ENCODE, '0, digs);
		digs = '{0, 1000, 1023, 0, 3, 1023};
		send_item(OP_ENCODE, '0, digs);
		send_item(OP_DECODE, 60'h0AB_CDEF_0123, digs);
		send_item(OP_DECODE, '1, digs);
		drain();

		// No digits in use: encode gives zero, decode flags any nonzero code.
		write_reg(CFG_DIGIT_COUNT, 11'd0);
		digs = '{1023, 1023, 1023, 1023, 1023, 1023};
		send_item(OP_ENCODE, '0, digs);
		send_item(OP_DECODE, '0, digs);
		send_item(OP_DECODE, 60'd1, digs);
		drain();

		// Digits above the count are ignored on encode; a leftover code flags on decode.
		r = '{10, 7, 2, 2, 2, 2};
		load_config(3'd2, r);
		write_reg(CFG_UNUSED, 11'h7FF);
		digs = '{9, 6, 1023, 1023, 1023, 1023};
		send_item(OP_ENCODE, '0, digs);
		digs = '{10, 6, 0, 0, 0, 0};
		send_item(OP_ENCODE, '0, digs);
		send_item(OP_DECODE, 60'd69, digs);
		send_item(OP_DECODE, 60'd70, digs);
		drain();
	endtask

	// Random items in bursts with random gaps under one configuration.
	task automatic run_random_phase(input int items, input bit pressure);
		logic [DIGIT_W-1:0] digs[LANES];
		int burst_left;
		burst_left = 0;
		for (int n = 0; n < items; n++) begin
			if (burst_left == 0) begin
				// Long runs with no gap at all alternate with short stutters.
				burst_left = $urandom_range(1, 40);
				if ($urandom_range(0, 2) != 0)
					hold_off($urandom_range(1, 12));
			end
			burst_left--;
			if (pressure && n == items / 2) begin
				start <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			pick_digits(digs);
			send_item(op_t'($urandom_range(0, 1)), pick_code(), digs);
		end
		drain();
	endtask

	task automatic test_random();
		logic [RADIX_W-1:0] r[LANES];
		r = '{1024, 1024, 1024, 1024, 1024, 1024};
		load_config(3'd6, r);
		run_random_phase(220, 1'b1);
		r = '{1, 1, 1, 1, 1, 1};
		load_config(3'd6, r);
		run_random_phase(150, 1'b0);
		r = '{2, 3, 5, 7, 11, 13};
		load_config(3'd4, r);
		run_random_phase(200, 1'b0);
		for (int p = 0; p < 5; p++) begin
			for (int i = 0; i < LANES; i++)
				r[i] = ($urandom_range(0, 7) == 0) ? RADIX_W'($urandom) :
					RADIX_W'($urandom_range(1, 1024));
			load_config(3'($urandom_range(0, 7)), r);
			run_random_phase(200, 1'b0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		opcode = OP_ENCODE;
		code_in = '0;
		for (int i = 0; i < LANES; i++) begin
			dig_in[i] = '0;
			shadow_radix[i] = 11'd1024;
		end
		cfg_valid = 1'b0;
		cfg_index = CFG_DIGIT_COUNT;
		cfg_data = '0;
		shadow_count = 3'd1;
		err_count = 0;
		idle_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config();
		test_directed();
		test_random();

		if (err_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/mre_pkg.sv
rtl/mre_enc_cell.sv
rtl/mre_div_cell.sv
rtl/mixed_radix_encode_decode.sv
dv/mixed_radix_encode_decode_tb.sv
